### sv/cgr_pkg.sv
// Shared types and constants for the character grid rasterizer.
// Used by cgr_front, cgr_back and char_grid_rasterizer_unit; depends on nothing.
package cgr_pkg;

  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 32;
  localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
  localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CW         = 13;

  typedef enum logic [3:0] {
    CMD_FILL    = 4'd0,
    CMD_POINT   = 4'd1,
    CMD_HRUN    = 4'd2,
    CMD_VRUN    = 4'd3,
    CMD_RECT    = 4'd4,
    CMD_DIAG_UP = 4'd5,
    CMD_DIAG_DN = 4'd6,
    CMD_DISC    = 4'd7,
    CMD_READ    = 4'd8
  } cmd_code_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_SEG,
    K_SCAN,
    K_READ
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SEG,
    B_SCAN,
    B_RDWAIT,
    B_RDDATA,
    B_DONE
  } bstate_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         cmd;
    logic [7:0]         symbol;
    logic signed [10:0] col_pos;
    logic signed [10:0] row_pos;
    logic [9:0]         width_len;
    logic [9:0]         height_len;
    logic [9:0]         radius;
  } req_t;

  typedef struct packed {
    logic [7:0] read_symbol;
    logic       read_inside;
  } res_t;

endpackage

### sv/char_grid_rasterizer_unit.sv
// Top level of the character grid rasterizer: front queue, back sequencer, result register.
// Depends on cgr_pkg, cgr_front and cgr_back.

// After reset the frame store is cleared one cell per cycle, and full stays high
// until that pass is over. Each request then yields one result. A fill or disc
// walks every cell of the grid in the sequencer, one cell per cycle, and a disc
// writes only the cells that pass its radius test; a read waits for earlier
// writes to land.
// Up to two requests queue ahead of the sequencer, and one result waits for pop.
module char_grid_rasterizer_unit import cgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_cmd,
  input  logic [7:0]         in_symbol,
  input  logic signed [10:0] in_col_pos,
  input  logic signed [10:0] in_row_pos,
  input  logic [9:0]         in_width_len,
  input  logic [9:0]         in_height_len,
  input  logic [9:0]         in_radius,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_read_symbol,
  output logic               out_read_inside
);

  logic q_valid, q_pop;
  req_t q_req;
  logic res_push, res_slot_free, clearing;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  cgr_front u_front (
    .clk(clk), .rst_n(rst_n), .hold(clearing), .push(push), .full(full),
    .in_cmd(in_cmd), .in_symbol(in_symbol), .in_col_pos(in_col_pos),
    .in_row_pos(in_row_pos), .in_width_len(in_width_len),
    .in_height_len(in_height_len), .in_radius(in_radius),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  cgr_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .res_slot_free(res_slot_free), .res_push(res_push), .res(res),
    .clearing(clearing)
  );

  assign res_slot_free   = !out_valid_r || pop;
  assign empty           = !out_valid_r;
  assign out_read_symbol = out_res_r.read_symbol;
  assign out_read_inside = out_res_r.read_inside;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> full)
    else $error("request accepted during the clearing pass");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!out_valid_r || pop))
    else $error("result written over a waiting result");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res.read_inside) |-> (res.read_symbol == 8'd0))
    else $error("nonzero symbol for a result outside the grid");

endmodule

### sv/cgr_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on cgr_pkg.
module cgr_front import cgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_cmd,
  input  logic [7:0]         in_symbol,
  input  logic signed [10:0] in_col_pos,
  input  logic signed [10:0] in_row_pos,
  input  logic [9:0]         in_width_len,
  input  logic [9:0]         in_height_len,
  input  logic [9:0]         in_radius,
  output logic               q_valid,
  output req_t               q_req,
  input  logic               q_pop
);

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  req_t       in_req;

  always_comb begin
    in_req.cmd        = in_cmd;
    in_req.symbol     = in_symbol;
    in_req.col_pos    = in_col_pos;
    in_req.row_pos    = in_row_pos;
    in_req.width_len  = in_width_len;
    in_req.height_len = in_height_len;
    in_req.radius     = in_radius;
    if (in_cmd inside {CMD_FILL, CMD_DISC}) begin
      in_req.kind = K_SCAN;
    end else if (in_cmd inside {[CMD_POINT:CMD_DIAG_DN]}) begin
      in_req.kind = K_SEG;
    end else if (in_cmd == CMD_READ) begin
      in_req.kind = K_READ;
    end else begin
      in_req.kind = K_NONE;
    end
  end

  assign full    = hold || (cnt_r == 2'd2);
  assign acc     = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = acc ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, acc} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

### sv/cgr_back.sv
// Back end: sequencer that walks runs or the whole grid, the frame store and reads.
// Depends on cgr_pkg; fed by cgr_front.
module cgr_back import cgr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  req_t q_req,
  output logic q_pop,
  input  logic res_slot_free,
  output logic res_push,
  output res_t res,
  output logic clearing
);

  typedef struct packed {
    logic signed [CW-1:0] col;
    logic signed [CW-1:0] row;
    logic [9:0]           len;
  } seg_t;

  function automatic logic signed [CW-1:0] sx11(logic signed [10:0] v);
    return {{(CW-11){v[10]}}, v};
  endfunction

  function automatic seg_t seg_load(req_t q, logic [1:0] s);
    seg_t                 sg;
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] h;
    w = {{(CW-10){1'b0}}, q.width_len};
    h = {{(CW-10){1'b0}}, q.height_len};
    sg.col = sx11(q.col_pos);
    sg.row = sx11(q.row_pos);
    sg.len = (q.cmd == CMD_POINT) ? 10'd1 : q.width_len;
    case (s)
      2'd1: sg.row = sx11(q.row_pos) + h - CW'(1);
      2'd2: sg.len = q.height_len;
      2'd3: begin
        sg.col = sx11(q.col_pos) + w - CW'(1);
        sg.len = q.height_len;
      end
      default: ;
    endcase
    return sg;
  endfunction

  function automatic logic on_grid(logic signed [CW-1:0] row, logic signed [CW-1:0] col);
    return (row >= 0) && (row < CW'(GRID_ROWS)) && (col >= 0) && (col < CW'(GRID_COLS));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic signed [CW-1:0] row,
                                                  logic signed [CW-1:0] col);
    return ADDR_W'(int'(row[ROW_W-1:0]) * GRID_COLS + int'(col[COL_W-1:0]));
  endfunction

  logic [7:0] mem [CELL_COUNT];

  bstate_t              state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic [1:0]           seg_r, seg_nxt;
  logic [9:0]           cnt_r, cnt_nxt;
  logic signed [CW-1:0] cur_col_r, cur_col_nxt;
  logic signed [CW-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]     sx_r, sx_nxt;
  logic [ROW_W-1:0]     sy_r, sy_nxt;
  logic [11:0]          limq_r, limq_nxt;
  logic                 clear_r, clear_nxt;
  logic                 p_v_r, p_v_nxt;
  logic                 p_test_r, p_test_nxt;
  logic signed [CW-1:0] p_col_r, p_col_nxt;
  logic signed [CW-1:0] p_row_r, p_row_nxt;
  logic [26:0]          p_sq_r, p_sq_nxt;
  logic [7:0]           rd_data_r;
  res_t                 res_r, res_nxt;

  logic                 seg_last;
  logic                 scan_last;
  logic signed [CW-1:0] dcol, drow;
  logic signed [CW-1:0] scol, srow, dx, dy;
  logic signed [2*CW-1:0] dx2, dy2;
  logic [19:0]          rsq;
  logic                 rd_in;
  logic                 wr_en;
  seg_t                 ld;

  assign seg_last  = (req_r.cmd == CMD_RECT) ? (seg_r == 2'd3) : 1'b1;
  assign scan_last = (sx_r == COL_W'(GRID_COLS - 1)) && (sy_r == ROW_W'(GRID_ROWS - 1));
  assign rd_in     = on_grid(sx11(req_r.row_pos), sx11(req_r.col_pos));
  assign rsq       = q_req.radius * q_req.radius;
  assign scol      = {{(CW-COL_W){1'b0}}, sx_r};
  assign srow      = {{(CW-ROW_W){1'b0}}, sy_r};
  assign dx        = scol - sx11(req_r.col_pos);
  assign dy        = srow - sx11(req_r.row_pos);
  assign dx2       = dx * dx;
  assign dy2       = dy * dy;

  always_comb begin
    dcol = '0;
    drow = '0;
    case (req_r.cmd)
      CMD_HRUN:    dcol = CW'(1);
      CMD_VRUN:    drow = CW'(1);
      CMD_DIAG_UP: begin
        dcol = CW'(1);
        drow = -CW'(1);
      end
      CMD_DIAG_DN: begin
        dcol = CW'(1);
        drow = CW'(1);
      end
      CMD_RECT: begin
        if (seg_r[1]) begin
          drow = CW'(1);
        end else begin
          dcol = CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_req.kind)
            K_SEG:   state_nxt = B_SEG;
            K_SCAN:  state_nxt = B_SCAN;
            K_READ:  state_nxt = B_RDWAIT;
            default: state_nxt = B_DONE;
          endcase
        end
      end
      B_SEG:    if (cnt_r == '0 && seg_last) state_nxt = B_DONE;
      B_SCAN:   if (scan_last) state_nxt = clear_r ? B_IDLE : B_DONE;
      B_RDWAIT: if (!p_v_r) state_nxt = B_RDDATA;
      B_RDDATA: state_nxt = B_DONE;
      B_DONE:   if (res_slot_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    req_nxt     = req_r;
    seg_nxt     = seg_r;
    cnt_nxt     = cnt_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    limq_nxt    = limq_r;
    clear_nxt   = clear_r;
    res_nxt     = res_r;
    p_v_nxt     = 1'b0;
    p_test_nxt  = 1'b0;
    p_col_nxt   = cur_col_r;
    p_row_nxt   = cur_row_r;
    p_sq_nxt    = p_sq_r;
    q_pop       = 1'b0;
    res_push    = 1'b0;
    ld          = seg_load(req_r, seg_r + 2'd1);
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          ld          = seg_load(q_req, 2'd0);
          req_nxt     = q_req;
          seg_nxt     = 2'd0;
          cnt_nxt     = ld.len;
          cur_col_nxt = ld.col;
          cur_row_nxt = ld.row;
          sx_nxt      = '0;
          sy_nxt      = '0;
          limq_nxt    = rsq[19:8];
          res_nxt     = '0;
        end
      end
      B_SEG: begin
        if (cnt_r != '0) begin
          p_v_nxt     = 1'b1;
          cur_col_nxt = cur_col_r + dcol;
          cur_row_nxt = cur_row_r + drow;
          cnt_nxt     = cnt_r - 10'd1;
        end else if (!seg_last) begin
          seg_nxt     = seg_r + 2'd1;
          cnt_nxt     = ld.len;
          cur_col_nxt = ld.col;
          cur_row_nxt = ld.row;
        end
      end
      B_SCAN: begin
        p_v_nxt    = 1'b1;
        p_col_nxt  = scol;
        p_row_nxt  = srow;
        p_test_nxt = (req_r.cmd == CMD_DISC);
        p_sq_nxt   = 27'(dx2) + 27'(dy2);
        if (sx_r == COL_W'(GRID_COLS - 1)) begin
          sx_nxt = '0;
          sy_nxt = sy_r + ROW_W'(1);
        end else begin
          sx_nxt = sx_r + COL_W'(1);
        end
        if (scan_last) begin
          clear_nxt = 1'b0;
        end
      end
      B_RDDATA: begin
        res_nxt.read_inside = rd_in;
        res_nxt.read_symbol = rd_in ? rd_data_r : 8'd0;
      end
      B_DONE: res_push = res_slot_free;
      default: ;
    endcase
  end

  assign res      = res_r;
  assign clearing = clear_r;
  assign wr_en    = p_v_r && on_grid(p_row_r, p_col_r) &&
                    (!p_test_r || (p_sq_r <= {15'd0, limq_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_SCAN;
      clear_r <= 1'b1;
      req_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      p_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clear_r <= clear_nxt;
      req_r   <= req_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      p_v_r   <= p_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r     <= seg_nxt;
    cnt_r     <= cnt_nxt;
    cur_col_r <= cur_col_nxt;
    cur_row_r <= cur_row_nxt;
    limq_r    <= limq_nxt;
    p_test_r  <= p_test_nxt;
    p_col_r   <= p_col_nxt;
    p_row_r   <= p_row_nxt;
    p_sq_r    <= p_sq_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cell_addr(p_row_r, p_col_r)] <= req_r.symbol;
    end
    if (state_r == B_RDWAIT) begin
      rd_data_r <= mem[cell_addr(sx11(req_r.row_pos), sx11(req_r.col_pos))];
    end
  end

endmodule

### test/tb_char_grid_rasterizer_unit.sv
// Self-checking testbench for char_grid_rasterizer_unit: a directed table, then random requests.
// Checked against an in-bench grid model or a row's typed result; uses cgr_pkg and the DUT.
`timescale 1ns / 1ps

module tb_char_grid_rasterizer_unit;
  import cgr_pkg::*;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQS = 270;

  typedef struct {
    logic [3:0]         cmd;
    logic [7:0]         symbol;
    logic signed [10:0] col_pos;
    logic signed [10:0] row_pos;
    logic [9:0]         width_len;
    logic [9:0]         height_len;
    logic [9:0]         radius;
    bit                 typed;
    res_t               typed_res;
  } grid_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [3:0]         in_cmd = '0;
  logic [7:0]         in_symbol = '0;
  logic signed [10:0] in_col_pos = '0;
  logic signed [10:0] in_row_pos = '0;
  logic [9:0]         in_width_len = '0;
  logic [9:0]         in_height_len = '0;
  logic [9:0]         in_radius = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_read_symbol;
  logic               out_read_inside;

  logic [7:0] grid_image [0:CELL_COUNT-1];
  res_t       pending_reads [$];
  grid_req_t  directed_rows [$];
  bit         cur_typed = 1'b0;
  res_t       cur_typed_res = '0;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 10;
  int         recv_idle_pct = 82;
  bit         hold_pop = 1'b0;
  bit         start_hold = 1'b0;

  char_grid_rasterizer_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  task automatic plot_cell(input logic [7:0] sym, input int c, input int r);
    if (r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS) grid_image[r*GRID_COLS+c] = sym;
  endtask

  task automatic draw_run(input logic [7:0] sym, input int c, input int r, input int len,
                          input int dc, input int dr);
    for (int k = 0; k < len; k++) plot_cell(sym, c + k*dc, r + k*dr);
  endtask

  task automatic apply_to_grid(output res_t res);
    int c;
    int r;
    int w;
    int h;
    longint lim;
    longint dx;
    longint dy;
    c = int'(in_col_pos);
    r = int'(in_row_pos);
    w = int'(in_width_len);
    h = int'(in_height_len);
    lim = longint'(in_radius) * longint'(in_radius);
    res = '0;
    case (in_cmd)
      CMD_FILL: for (int i = 0; i < CELL_COUNT; i++) grid_image[i] = in_symbol;
      CMD_POINT: plot_cell(in_symbol, c, r);
      CMD_HRUN: draw_run(in_symbol, c, r, w, 1, 0);
      CMD_VRUN: draw_run(in_symbol, c, r, w, 0, 1);
      CMD_RECT: begin
        draw_run(in_symbol, c, r, w, 1, 0);
        draw_run(in_symbol, c, r + h - 1, w, 1, 0);
        draw_run(in_symbol, c, r, h, 0, 1);
        draw_run(in_symbol, c + w - 1, r, h, 0, 1);
      end
      CMD_DIAG_UP: draw_run(in_symbol, c, r, w, 1, -1);
      CMD_DIAG_DN: draw_run(in_symbol, c, r, w, 1, 1);
      CMD_DISC: begin
        for (int y = 0; y < GRID_ROWS; y++) begin
          for (int x = 0; x < GRID_COLS; x++) begin
            dx = x - c;
            dy = y - r;
            if (256 * (dx*dx + dy*dy) <= lim) grid_image[y*GRID_COLS+x] = in_symbol;
          end
        end
      end
      CMD_READ: begin
        if (r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS) begin
          res.read_symbol = grid_image[r*GRID_COLS+c];
          res.read_inside = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (pop && !empty) begin
        got.read_symbol = out_read_symbol;
        got.read_inside = out_read_inside;
        if (pending_reads.size() == 0) begin
          report("unexpected result", int'(got), 0);
        end else begin
          want = pending_reads.pop_front();
          if (got.read_symbol !== want.read_symbol)
            report("read_symbol", int'(got.read_symbol), int'(want.read_symbol));
          if (got.read_inside !== want.read_inside)
            report("read_inside", int'(got.read_inside), int'(want.read_inside));
        end
      end
      if (push && !full) begin
        apply_to_grid(want);
        pending_reads.push_back(cur_typed ? cur_typed_res : want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_pop) pop = 1'b0;
    else pop = ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (start_hold);
    hold_pop = 1'b1;
    repeat (400) @(posedge clk);
    hold_pop = 1'b0;
  end

  task automatic send_req(input grid_req_t q);
    @(negedge clk);
    in_cmd = q.cmd;
    in_symbol = q.symbol;
    in_col_pos = q.col_pos;
    in_row_pos = q.row_pos;
    in_width_len = q.width_len;
    in_height_len = q.height_len;
    in_radius = q.radius;
    cur_typed = q.typed;
    cur_typed_res = q.typed_res;
    push = 1'b1;
    do @(posedge clk); while (full);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  function automatic grid_req_t row(input logic [3:0] cmd, input int sym, input int c,
                                    input int r, input int w, input int h, input int rad,
                                    input bit typed = 0, input int sym_exp = 0,
                                    input bit in_exp = 0);
    grid_req_t q;
    q.cmd = cmd;
    q.symbol = 8'(sym);
    q.col_pos = 11'(c);
    q.row_pos = 11'(r);
    q.width_len = 10'(w);
    q.height_len = 10'(h);
    q.radius = 10'(rad);
    q.typed = typed;
    q.typed_res.read_symbol = 8'(sym_exp);
    q.typed_res.read_inside = in_exp;
    return q;
  endfunction

  function automatic int rand_pos(input int span);
    if ($urandom_range(7) == 0) return $urandom_range(2047) - 1024;
    return $urandom_range(span + 15) - 8;
  endfunction

  function automatic grid_req_t random_req();
    grid_req_t q;
    int pick;
    pick = $urandom_range(99);
    q = row(CMD_READ, $urandom_range(255), rand_pos(GRID_COLS), rand_pos(GRID_ROWS),
            $urandom_range(80), $urandom_range(40), $urandom_range(1023));
    if ($urandom_range(15) == 0) q.width_len = 10'($urandom_range(1023));
    if ($urandom_range(15) == 0) q.height_len = 10'($urandom_range(1023));
    if (pick < 35) q.cmd = CMD_READ;
    else if (pick < 45) q.cmd = CMD_POINT;
    else if (pick < 53) q.cmd = CMD_HRUN;
    else if (pick < 61) q.cmd = CMD_VRUN;
    else if (pick < 69) q.cmd = CMD_DIAG_UP;
    else if (pick < 77) q.cmd = CMD_DIAG_DN;
    else if (pick < 86) q.cmd = CMD_RECT;
    else if (pick < 89) q.cmd = CMD_FILL;
    else if (pick < 94) q.cmd = CMD_DISC;
    else q.cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    return q;
  endfunction

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) grid_image[i] = '0;
    directed_rows = '{
      row(CMD_READ, 8'h00, 0, 0, 0, 0, 0, 1, 8'h00, 1),
      row(CMD_READ, 8'hFF, 63, 31, 1023, 1023, 1023, 1, 8'h00, 1),
      row(CMD_READ, 8'h00, -1, 0, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_READ, 8'h00, 64, 32, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_READ, 8'h00, 1023, -1024, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_FILL, 8'hFF, 0, 0, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_READ, 8'h00, 5, 5, 0, 0, 0, 1, 8'hFF, 1),
      row(CMD_POINT, 8'hA5, 0, 0, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_READ, 8'h00, 0, 0, 0, 0, 0, 1, 8'hA5, 1),
      row(CMD_POINT, 8'h11, -1024, -1024, 0, 0, 0, 1, 8'h00, 0),
      row(CMD_HRUN, 8'h22, -2, 3, 10, 0, 0),
      row(CMD_READ, 8'h00, 0, 3, 0, 0, 0),
      row(CMD_VRUN, 8'h33, 63, 30, 1023, 0, 0),
      row(CMD_READ, 8'h00, 63, 31, 0, 0, 0),
      row(CMD_RECT, 8'h44, 10, 10, 0, 4, 0),
      row(CMD_READ, 8'h00, 9, 11, 0, 0, 0),
      row(CMD_RECT, 8'h45, 20, 12, 5, 0, 0),
      row(CMD_DIAG_UP, 8'h66, 2, 2, 0, 0, 0),
      row(CMD_DIAG_UP, 8'h67, 0, 31, 40, 0, 0),
      row(CMD_DIAG_DN, 8'h68, -5, -5, 50, 0, 0),
      row(CMD_DISC, 8'h55, 32, 16, 0, 0, 0),
      row(CMD_READ, 8'h00, 32, 16, 0, 0, 0, 1, 8'h55, 1),
      row(CMD_DISC, 8'h00, 32, 16, 0, 0, 160),
      row(CMD_UNUSED_HI, 8'hFF, 0, 0, 1023, 1023, 1023, 1, 8'h00, 0),
      row(CMD_RECT, 8'h77, -1024, -1024, 1023, 1023, 0)
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[i]) send_req(directed_rows[i]);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 10;
      end
      if (n == 2 * RANDOM_REQS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        start_hold = 1'b1;
      end
      send_req(random_req());
    end
    @(negedge clk);
    push = 1'b0;
    cur_typed = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
